// ----- rtl/core/dmir_pkg.sv -----
// Shared types and constants for the distortion map rectifier.
`timescale 1ns / 1ps
`default_nettype none

package dmir_pkg;

    localparam int MAP_SIDE   = 64;
    localparam int MAP_IDX_W  = $clog2(MAP_SIDE);
    localparam int MAP_AW     = 2 * MAP_IDX_W;
    localparam int MAP_POINTS = MAP_SIDE * MAP_SIDE;
    localparam int COORD_W    = 16;
    localparam int SRC_PIXELS = 262144;
    localparam int SRC_AW     = $clog2(SRC_PIXELS);
    localparam int CFG_W      = 11;
    localparam int SIDE_W     = 10;
    localparam int FRAC_W     = 16;
    localparam int PROD_BITS  = 46;

    // divider: quotient of a Q16 map coordinate, DIV_STEPS bits per stage
    localparam int DIV_NUM_W  = 33;
    localparam int DIV_Q_W    = 24;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_Q_W / DIV_STEPS;

    localparam int BLEND_W    = 54;
    localparam int BLEND_LAT  = 4;
    localparam int MUL_W      = PROD_BITS + 1 + CFG_W;
    localparam logic [BLEND_W-2:0] UNIT_Q46 = (BLEND_W-1)'(1) << PROD_BITS;

    localparam logic [1:0] CMD_MAP_WRITE   = 2'd0;
    localparam logic [1:0] CMD_PIXEL_WRITE = 2'd1;
    localparam logic [1:0] CMD_QUERY       = 2'd2;

    localparam logic [1:0] REG_DEST_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DEST_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
    localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

    localparam logic [7:0] REJECT_VALUE = 8'hFF;

    typedef struct packed {
        logic [1:0]                command;
        logic [MAP_AW-1:0]         map_index;
        logic signed [COORD_W-1:0] map_x;
        logic signed [COORD_W-1:0] map_y;
        logic [SRC_AW-1:0]         pixel_address;
        logic [7:0]                pixel_value;
        logic [SIDE_W-1:0]         dest_col;
        logic [SIDE_W-1:0]         dest_row;
    } item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic       in_range;
    } result_t;

    typedef struct packed {
        item_t item;
        logic  reject;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/dmir_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dmir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dmir_div.sv -----
// Pipelined restoring divider, STEPS quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none

module dmir_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 11,
    parameter int Q_W   = 24,
    parameter int STEPS = 4
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);

    localparam int STAGES = Q_W / STEPS;

    // numerator low bits shift out the top while quotient bits shift in
    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [Q_W-1:0]   lq_reg  [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [DEN_W-1:0] r_in;
        logic [Q_W-1:0]   w_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W-1:0] r;
        logic [Q_W-1:0]   w;
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] d;

        if (s == 0)
        begin : g_first
            // top numerator bits are below the divisor for a valid query
            assign r_in = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
            assign w_in = num[Q_W-1:0];
            assign d_in = den;
        end
        else
        begin : g_next
            assign r_in = rem_reg[s-1];
            assign w_in = lq_reg[s-1];
            assign d_in = den_reg[s-1];
        end

        always_comb
        begin
            r = r_in;
            w = w_in;
            d = d_in;
            t = '0;
            for (int k = 0; k < STEPS; k++)
            begin
                t = {r, w[Q_W-1]};
                w = {w[Q_W-2:0], 1'b0};
                if (t >= {1'b0, d})
                begin
                    t    = t - {1'b0, d};
                    w[0] = 1'b1;
                end
                r = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= r;
                lq_reg[s]  <= w;
                den_reg[s] <= d;
            end
        end
    end

    assign quo = lq_reg[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/dmir_blend.sv -----
// Four-stage bilinear blend of four map values.
`timescale 1ns / 1ps
`default_nettype none

module dmir_blend
    import dmir_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [COORD_W-1:0] a,
    input  wire logic signed [COORD_W-1:0] b,
    input  wire logic signed [COORD_W-1:0] c,
    input  wire logic signed [COORD_W-1:0] d,
    input  wire logic        [FRAC_W-1:0]  wx,
    input  wire logic        [FRAC_W-1:0]  wy,
    output logic signed      [BLEND_W-1:0] res
);

    localparam int P_W = COORD_W + FRAC_W + 2;
    localparam int T_W = P_W + 1;
    localparam int Q_W = T_W + FRAC_W + 2;
    localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1) << FRAC_W;

    logic [FRAC_W:0]         wxn;
    logic [FRAC_W:0]         wyn;
    logic signed [P_W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [T_W-1:0]   top_reg, bot_reg;
    logic signed [Q_W-1:0]   q0_reg, q1_reg;
    logic [FRAC_W-1:0]       wy1_reg, wy2_reg;

    assign wxn = ONE - {1'b0, wx};
    assign wyn = ONE - {1'b0, wy2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= a * $signed({1'b0, wxn});
            p1_reg  <= b * $signed({2'b00, wx});
            p2_reg  <= c * $signed({1'b0, wxn});
            p3_reg  <= d * $signed({2'b00, wx});
            wy1_reg <= wy;

            top_reg <= T_W'(p0_reg) + T_W'(p1_reg);
            bot_reg <= T_W'(p2_reg) + T_W'(p3_reg);
            wy2_reg <= wy1_reg;

            q0_reg  <= top_reg * $signed({1'b0, wyn});
            q1_reg  <= bot_reg * $signed({2'b00, wy2_reg});

            res     <= BLEND_W'(q0_reg) + BLEND_W'(q1_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/distortion_map_image_rectify.sv -----
// Top level: distortion map rectifier pipeline.
//
//  channel  | dir | handshake           | word
//  ---------+-----+---------------------+---------------------------
//  item     | in  | item_valid/stall    | item_t (write or query)
//  result   | out | result_valid/stall  | result_t (one per query)
//  cfg      | in  | cfg_write           | cfg_index, cfg_data
//
// One word per cycle while no result is stalled. A query passes through
// the six-stage coordinate dividers, the map RAM read, the four-stage
// blend, source scaling and the source RAM read.
// Writes are applied at the stage where queries read the same RAM, so
// order is kept. A stalled result freezes the whole pipeline.
// rst_n clears valid bits and sets the configuration registers to 640/240 only.
`timescale 1ns / 1ps
`default_nettype none

module distortion_map_image_rectify
    import dmir_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int ST_MAP   = DIV_STAGES;
    localparam int ST_RANGE = ST_MAP + 1 + BLEND_LAT;
    localparam int ST_ADDR  = ST_RANGE + 2;
    localparam int ST_SRC   = ST_ADDR + 1;
    localparam int NSTG     = ST_SRC + 1;

    logic [CFG_W-1:0] dest_width_reg, dest_height_reg, src_width_reg, src_height_reg;
    logic             en;
    side_t            sp_reg  [NSTG];
    logic             vld_reg [NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= CFG_W'(640);
            dest_height_reg <= CFG_W'(240);
            src_width_reg   <= CFG_W'(640);
            src_height_reg  <= CFG_W'(240);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEST_WIDTH:  dest_width_reg  <= cfg_data;
                REG_DEST_HEIGHT: dest_height_reg <= cfg_data;
                REG_SRC_WIDTH:   src_width_reg   <= cfg_data;
                REG_SRC_HEIGHT:  src_height_reg  <= cfg_data;
                default:         dest_width_reg  <= dest_width_reg;
            endcase
        end
    end

    assign en         = !result_valid || !result_stall;
    assign item_stall = !en;

    // entry: query outside the destination, or with a zero destination size, is rejected up front
    side_t entry;
    always_comb
    begin
        entry.item   = item;
        entry.reject = (dest_width_reg == '0) || (dest_height_reg == '0) ||
                       ({1'b0, item.dest_col} >= dest_width_reg) ||
                       ({1'b0, item.dest_row} >= dest_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg[0] <= entry;
            for (int i = 1; i < NSTG; i++)
            begin
                sp_reg[i] <= sp_reg[i-1];
            end
        end
    end

    // map-space scaling: (SIDE-1)*col/W and (SIDE-2)*(H-row)/H in Q16
    logic [CFG_W-1:0]     h_minus_row;
    logic [16:0]          col_sc, row_sc;
    logic [DIV_Q_W-1:0]   quo_x, quo_y;

    assign h_minus_row = dest_height_reg - {1'b0, sp_reg[0].item.dest_row};
    assign col_sc = 17'(MAP_SIDE - 1) * 17'(sp_reg[0].item.dest_col);
    assign row_sc = 17'(MAP_SIDE - 2) * 17'(h_minus_row);

    dmir_div #(.NUM_W(DIV_NUM_W), .DEN_W(CFG_W), .Q_W(DIV_Q_W), .STEPS(DIV_STEPS)) u_div_x (
        .clk (clk),
        .en  (en),
        .num ({col_sc, 16'h0000}),
        .den (dest_width_reg),
        .quo (quo_x)
    );

    dmir_div #(.NUM_W(DIV_NUM_W), .DEN_W(CFG_W), .Q_W(DIV_Q_W), .STEPS(DIV_STEPS)) u_div_y (
        .clk (clk),
        .en  (en),
        .num ({row_sc, 16'h0000}),
        .den (dest_height_reg),
        .quo (quo_y)
    );

    // corner addresses; map RAM is replicated once per corner
    logic [MAP_IDX_W-1:0] x1, y1, x2, y2;
    logic [MAP_AW-1:0]    corner_addr [4];
    logic                 map_we;
    logic [FRAC_W-1:0]    wx_reg, wy_reg;
    logic [2*COORD_W-1:0] corner_data [4];

    assign x1 = quo_x[FRAC_W+MAP_IDX_W-1:FRAC_W];
    assign y1 = quo_y[FRAC_W+MAP_IDX_W-1:FRAC_W];
    assign x2 = (x1 == MAP_IDX_W'(MAP_SIDE - 1)) ? x1 : x1 + 1'b1;
    assign y2 = (y1 == MAP_IDX_W'(MAP_SIDE - 1)) ? y1 : y1 + 1'b1;
    assign corner_addr[0] = {y1, x1};
    assign corner_addr[1] = {y1, x2};
    assign corner_addr[2] = {y2, x1};
    assign corner_addr[3] = {y2, x2};
    assign map_we = en && vld_reg[ST_MAP] &&
                    (sp_reg[ST_MAP].item.command == CMD_MAP_WRITE);

    for (genvar k = 0; k < 4; k++)
    begin : g_map
        dmir_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAP_POINTS)) u_map_ram (
            .clk   (clk),
            .we    (map_we),
            .waddr (sp_reg[ST_MAP].item.map_index),
            .wdata ({sp_reg[ST_MAP].item.map_x, sp_reg[ST_MAP].item.map_y}),
            .re    (en),
            .raddr (corner_addr[k]),
            .rdata (corner_data[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quo_x[FRAC_W-1:0];
            wy_reg <= quo_y[FRAC_W-1:0];
        end
    end

    logic signed [BLEND_W-1:0] dx, dy;

    dmir_blend u_blend_x (
        .clk (clk),
        .en  (en),
        .a   (corner_data[0][2*COORD_W-1:COORD_W]),
        .b   (corner_data[1][2*COORD_W-1:COORD_W]),
        .c   (corner_data[2][2*COORD_W-1:COORD_W]),
        .d   (corner_data[3][2*COORD_W-1:COORD_W]),
        .wx  (wx_reg),
        .wy  (wy_reg),
        .res (dx)
    );

    dmir_blend u_blend_y (
        .clk (clk),
        .en  (en),
        .a   (corner_data[0][COORD_W-1:0]),
        .b   (corner_data[1][COORD_W-1:0]),
        .c   (corner_data[2][COORD_W-1:0]),
        .d   (corner_data[3][COORD_W-1:0]),
        .wx  (wx_reg),
        .wy  (wy_reg),
        .res (dy)
    );

    // range check and scaling to source pixels
    logic             oor_next;
    logic             oor1_reg, oor2_reg, oor3_reg;
    logic [MUL_W-1:0] mulx_reg, muly_reg;

    assign oor_next = dx[BLEND_W-1] || (dx[BLEND_W-2:0] > UNIT_Q46) ||
                      dy[BLEND_W-1] || (dy[BLEND_W-2:0] > UNIT_Q46) ||
                      (src_width_reg == '0) || (src_height_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor1_reg <= oor_next;
            mulx_reg <= MUL_W'(dx[PROD_BITS:0]) * MUL_W'(src_width_reg);
            muly_reg <= MUL_W'(dy[PROD_BITS:0]) * MUL_W'(src_height_reg);
        end
    end

    // clamp a coordinate that lands exactly on the far edge
    logic [CFG_W:0]     px_raw, py_raw;
    logic [CFG_W-1:0]   sw_m1, sh_m1, px_c, py_c;
    logic [CFG_W-1:0]   px_reg;
    logic [2*CFG_W-1:0] pyw_reg;

    assign px_raw = mulx_reg[MUL_W-1:PROD_BITS];
    assign py_raw = muly_reg[MUL_W-1:PROD_BITS];
    assign sw_m1  = src_width_reg - 1'b1;
    assign sh_m1  = src_height_reg - 1'b1;
    assign px_c   = (px_raw > {1'b0, sw_m1}) ? sw_m1 : px_raw[CFG_W-1:0];
    assign py_c   = (py_raw > {1'b0, sh_m1}) ? sh_m1 : py_raw[CFG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor2_reg <= oor1_reg;
            px_reg   <= px_c;
            pyw_reg  <= (2*CFG_W)'(py_c) * (2*CFG_W)'(src_width_reg);
        end
    end

    // source image read, or write for a pixel word
    logic [2*CFG_W-1:0] src_sum;
    logic               src_we;
    logic [7:0]         src_data;

    assign src_sum = (2*CFG_W)'(px_reg) + pyw_reg;
    assign src_we  = en && vld_reg[ST_ADDR] &&
                     (sp_reg[ST_ADDR].item.command == CMD_PIXEL_WRITE);

    dmir_ram #(.WIDTH(8), .DEPTH(SRC_PIXELS)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (sp_reg[ST_ADDR].item.pixel_address),
        .wdata (sp_reg[ST_ADDR].item.pixel_value),
        .re    (en),
        .raddr (src_sum[SRC_AW-1:0]),
        .rdata (src_data)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor3_reg <= oor2_reg;
        end
    end

    // output register
    logic rej;
    assign rej = sp_reg[ST_SRC].reject || oor3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            result_valid <= vld_reg[ST_SRC] && (sp_reg[ST_SRC].item.command == CMD_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.brightness <= rej ? REJECT_VALUE : src_data;
            result.in_range   <= !rej;
        end
    end

    a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_range |-> result.brightness == REJECT_VALUE)
        else $error("rejected result without reject brightness");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled with no stalled result");

    a_query_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[ST_SRC] && sp_reg[ST_SRC].item.command == CMD_QUERY |=> result_valid)
        else $error("query word lost at output");

endmodule

`default_nettype wire

// ----- test/tb_distortion_map_image_rectify.sv -----
// Testbench for the distortion map rectifier: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_distortion_map_image_rectify;
    import dmir_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    // Tracks the map, the source image and the registers, and holds the
    // brightness words still owed by the block.
    class rectify_scoreboard;
        bit signed [COORD_W-1:0] map_x_pt[MAP_POINTS];
        bit signed [COORD_W-1:0] map_y_pt[MAP_POINTS];
        bit                      map_done[MAP_POINTS];
        byte unsigned            src_pix[SRC_PIXELS];
        bit                      pix_done[SRC_PIXELS];
        int unsigned dest_w = 640, dest_h = 240, src_w = 640, src_h = 240;
        result_t     owed[$];
        int unsigned missing_pts[$];
        int unsigned missing_pix[$];
        int          errors;

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                REG_DEST_WIDTH:  dest_w = val;
                REG_DEST_HEIGHT: dest_h = val;
                REG_SRC_WIDTH:   src_w = val;
                default:         src_h = val;
            endcase
        endfunction

        function int unsigned point_at(longint row, longint col);
            if (row > MAP_SIDE - 1) row = MAP_SIDE - 1;
            if (col > MAP_SIDE - 1) col = MAP_SIDE - 1;
            return int'(row * MAP_SIDE + col);
        endfunction

        function longint bilerp(longint a, longint b, longint c, longint d,
                                longint wx, longint wy);
            longint top, bot;
            top = a * (65536 - wx) + b * wx;
            bot = c * (65536 - wx) + d * wx;
            return top * (65536 - wy) + bot * wy;
        endfunction

        // Brightness of a query; unwritten entries it touches go to the
        // missing lists so the stimulus can load them first.
        function result_t rectify(item_t q);
            result_t r;
            longint cx, cy, wx, wy, dx, dy, px, py, x1, y1;
            int unsigned k[4];
            int unsigned a;
            r.brightness = REJECT_VALUE;
            r.in_range = 1'b0;
            if (dest_w == 0 || dest_h == 0 || q.dest_col >= dest_w || q.dest_row >= dest_h)
                return r;
            cx = (longint'(q.dest_col) * 63 << 16) / dest_w;
            cy = (longint'(dest_h - q.dest_row) * 62 << 16) / dest_h;
            x1 = cx >> 16;
            y1 = cy >> 16;
            wx = cx & 64'hFFFF;
            wy = cy & 64'hFFFF;
            k[0] = point_at(y1, x1);
            k[1] = point_at(y1, x1 + 1);
            k[2] = point_at(y1 + 1, x1);
            k[3] = point_at(y1 + 1, x1 + 1);
            foreach (k[i])
                if (!map_done[k[i]])
                    missing_pts.push_back(k[i]);
            dx = bilerp(map_x_pt[k[0]], map_x_pt[k[1]], map_x_pt[k[2]], map_x_pt[k[3]],
                        wx, wy);
            dy = bilerp(map_y_pt[k[0]], map_y_pt[k[1]], map_y_pt[k[2]], map_y_pt[k[3]],
                        wx, wy);
            if (dx < 0 || dx > (64'sd1 << PROD_BITS) || dy < 0 || dy > (64'sd1 << PROD_BITS))
                return r;
            if (src_w == 0 || src_h == 0)
                return r;
            px = (dx * src_w) >>> PROD_BITS;
            py = (dy * src_h) >>> PROD_BITS;
            // coordinate landing exactly on the far edge takes the last pixel
            if (px > src_w - 1) px = src_w - 1;
            if (py > src_h - 1) py = src_h - 1;
            a = int'((px + py * src_w) % SRC_PIXELS);
            if (!pix_done[a])
                missing_pix.push_back(a);
            r.brightness = src_pix[a];
            r.in_range = 1'b1;
            return r;
        endfunction

        function void note_item(item_t w);
            case (w.command)
                CMD_MAP_WRITE:
                begin
                    map_x_pt[w.map_index] = w.map_x;
                    map_y_pt[w.map_index] = w.map_y;
                    map_done[w.map_index] = 1'b1;
                end
                CMD_PIXEL_WRITE:
                begin
                    src_pix[w.pixel_address] = w.pixel_value;
                    pix_done[w.pixel_address] = 1'b1;
                end
                CMD_QUERY: owed.push_back(rectify(w));
                default: ;
            endcase
        endfunction

        task check_result(result_t r);
            result_t e;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected word %h", r));
                return;
            end
            e = owed.pop_front();
            if (r.brightness !== e.brightness)
                report($sformatf("brightness %h, want %h", r.brightness, e.brightness));
            if (r.in_range !== e.in_range)
                report($sformatf("in_range %b, want %b", r.in_range, e.in_range));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    item_t            item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_write = 1'b0;
    logic [1:0]       cfg_index = REG_DEST_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    rectify_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    distortion_map_image_rectify DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);

    task automatic send_word(item_t w);
        while (!calm && $urandom_range(99) < 15)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(w);
    endtask

    function automatic item_t noise_word();
        item_t w;
        w = $bits(item_t)'({$urandom, $urandom, $urandom, $urandom});
        return w;
    endfunction

    function automatic logic [COORD_W-1:0] coord_value();
        if ($urandom_range(99) < 8)
            return COORD_W'($urandom);
        if ($urandom_range(99) < 5)
            return 16'd16384;
        return COORD_W'($urandom_range(16384));
    endfunction

    task automatic write_point(int unsigned idx, logic [15:0] x, logic [15:0] y);
        item_t w;
        w = noise_word();
        w.command = CMD_MAP_WRITE;
        w.map_index = MAP_AW'(idx);
        w.map_x = x;
        w.map_y = y;
        send_word(w);
    endtask

    task automatic write_pixel(int unsigned addr, logic [7:0] v);
        item_t w;
        w = noise_word();
        w.command = CMD_PIXEL_WRITE;
        w.pixel_address = SRC_AW'(addr);
        w.pixel_value = v;
        send_word(w);
    endtask

    // loads whatever the query would read unwritten, then sends it
    task automatic query(int unsigned col, int unsigned row);
        item_t w;
        result_t dummy;
        w = noise_word();
        w.command = CMD_QUERY;
        w.dest_col = SIDE_W'(col);
        w.dest_row = SIDE_W'(row);
        forever
        begin
            sb.missing_pts.delete();
            sb.missing_pix.delete();
            dummy = sb.rectify(w);
            if (sb.missing_pts.size() != 0)
            begin
                foreach (sb.missing_pts[i])
                    if (!sb.map_done[sb.missing_pts[i]])
                        write_point(sb.missing_pts[i], coord_value(), coord_value());
            end
            else if (sb.missing_pix.size() != 0)
                write_pixel(sb.missing_pix[0], 8'($urandom));
            else
                break;
        end
        send_word(w);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_phase(int n);
        item_t w;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                if (sb.dest_w == 0 || sb.dest_h == 0 || $urandom_range(99) < 15)
                    query($urandom_range(1023), $urandom_range(1023));
                else
                    query($urandom_range(sb.dest_w - 1), $urandom_range(sb.dest_h - 1));
            end
            else if (pick < 75)
                write_point($urandom_range(MAP_POINTS - 1), coord_value(), coord_value());
            else if (pick < 92)
                write_pixel($urandom_range(SRC_PIXELS - 1), 8'($urandom));
            else
            begin
                w = noise_word();
                w.command = CMD_UNUSED;
                send_word(w);
                i--;
            end
        end
    endtask

    initial
    begin
        int unsigned phase_cfg[6][4] = '{
            '{640, 240, 640, 240}, '{1, 1, 1, 1}, '{1024, 1024, 1024, 1024},
            '{37, 5, 16, 12}, '{0, 7, 0, 9}, '{200, 600, 1024, 3}};
        item_t w;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner of the map driven far negative: rejected query
        write_point(0, 16'h8000, 16'h8000);
        write_point(1, 16'h8000, 16'h7FFF);
        write_point(64, 16'h8000, 16'h8000);
        write_point(65, 16'h8000, 16'h8000);
        query(0, 239);
        // point at exactly 1.0: clamps to the last source pixel
        write_point(3968, 16'd16384, 16'd16384);
        write_point(3969, 16'd16384, 16'd16384);
        write_point(4032, 16'd16384, 16'd16384);
        write_point(4033, 16'd16384, 16'd16384);
        query(0, 0);
        write_point(4095, 16'h7FFF, 16'h0000);
        write_point(4094, 16'h0000, 16'h0000);
        write_pixel(0, 8'h00);
        write_pixel(SRC_PIXELS - 1, 8'hFF);
        query(639, 239);
        query(1023, 1023);
        query(640, 0);
        query(0, 240);
        w = noise_word();
        w.command = CMD_UNUSED;
        send_word(w);
        query(320, 120);

        // queries load their own map points and pixels, so few words per phase
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                drain();
                set_reg(REG_DEST_WIDTH, phase_cfg[p][0]);
                set_reg(REG_DEST_HEIGHT, phase_cfg[p][1]);
                set_reg(REG_SRC_WIDTH, phase_cfg[p][2]);
                set_reg(REG_SRC_HEIGHT, phase_cfg[p][3]);
            end
            calm = (p == 3);
            if (p == 2)
                hold_request = 1'b1;
            random_phase(80);
        end
        calm = 1'b0;
        drain();

        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
